// ===== hw/rtl/chained_hash_set_of_tuples_core_assert.svh =====
// Assertion macros shared by the hash set modules.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef CHAINED_HASH_SET_OF_TUPLES_CORE_ASSERT_SVH
`define CHAINED_HASH_SET_OF_TUPLES_CORE_ASSERT_SVH

// The condition holds at every sampled edge.
`define CHST_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CHST_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CHST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/chst_pkg.sv =====
package chst_pkg;

    // Packed key width: vertex count, edge count, three degrees and the flag.
    localparam int KEY_W = 49;

    // Number of key fields that enter the hash.
    localparam int HASH_TERMS = 6;

    // The hash 31*h + field over six fields, unrolled: 17*31^6 plus each
    // field times a power of 31, all modulo 2^32.
    localparam logic [31:0] HASH_SEED_TERM = 32'd2202660689;
    localparam logic [31:0] HASH_MUL [HASH_TERMS] = '{
        32'd28629151, 32'd923521, 32'd29791, 32'd961, 32'd31, 32'd1
    };

    // One request transaction.
    typedef struct packed {
        logic        command;
        logic [7:0]  vertex_count;
        logic [15:0] edge_count;
        logic [7:0]  least_degree;
        logic [7:0]  greatest_degree;
        logic [7:0]  added_vertex_degree;
        logic        greatest_raised;
    } query_t;

    // One reply transaction.
    typedef struct packed {
        logic found;
        logic added;
        logic full_res;
    } reply_t;

    // Command codes.
    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_NODE
    } back_state_t;

endpackage

// ===== hw/rtl/chst_front.sv =====
module chst_front
    import chst_pkg::*;
#(
    parameter int BUCKET_BITS = 10
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             query_valid,
    output logic                             query_stall,
    input  query_t                           query,
    input  logic                             clearing,
    input  logic                             q_full,
    output logic                             q_push,
    output logic [BUCKET_BITS+KEY_W:0]       q_push_data
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_cmd_reg;
    logic [KEY_W-1:0]       s1_key_reg;
    logic [BUCKET_BITS-1:0] s1_term_reg  [HASH_TERMS];
    logic [BUCKET_BITS-1:0] s1_term_next [HASH_TERMS];
    logic                   accept;
    logic [BUCKET_BITS-1:0] bucket;

    // The stage takes a new transaction when it is empty or drains into the queue, and not while clearing.
    assign q_push      = s1_valid_reg && !q_full;
    assign query_stall = clearing || (s1_valid_reg && q_full);
    assign accept      = query_valid && !query_stall;

    // Each hash term is one field times a constant power of 31, low bits only.
    always_comb
    begin
        logic [31:0] field [HASH_TERMS];
        logic [31:0] prod;
        field[0] = 32'(query.vertex_count);
        field[1] = 32'(query.edge_count);
        field[2] = 32'(query.least_degree);
        field[3] = 32'(query.greatest_degree);
        field[4] = 32'(query.added_vertex_degree);
        field[5] = 32'(query.greatest_raised);
        for (int i = 0; i < HASH_TERMS; i++)
        begin
            prod            = field[i] * HASH_MUL[i];
            s1_term_next[i] = prod[BUCKET_BITS-1:0];
        end
    end

    // Stage valid tracking.
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (q_push)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Payload of the first stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= query.command;
            s1_key_reg <= {query.greatest_raised, query.added_vertex_degree,
                           query.greatest_degree, query.least_degree,
                           query.edge_count, query.vertex_count};
            for (int i = 0; i < HASH_TERMS; i++)
                s1_term_reg[i] <= s1_term_next[i];
        end
    end

    // The bucket is the sum of the terms and the seed, modulo the bucket count.
    always_comb
    begin
        bucket = HASH_SEED_TERM[BUCKET_BITS-1:0];
        for (int i = 0; i < HASH_TERMS; i++)
            bucket = bucket + s1_term_reg[i];
    end

    assign q_push_data = {bucket, s1_cmd_reg, s1_key_reg};

endmodule

// ===== hw/rtl/chst_queue.sv =====
`include "chained_hash_set_of_tuples_core_assert.svh"

module chst_queue
    import chst_pkg::*;
#(
    parameter int ENTRY_W = 60
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    output logic               full,
    input  logic               pop,
    output logic [ENTRY_W-1:0] pop_data,
    output logic               empty
);

    localparam int DEPTH = 2;

    logic [ENTRY_W-1:0] mem_reg [DEPTH];
    logic [0:0]         wr_ptr_reg;
    logic [0:0]         rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    assign full     = (count_reg == 2'(DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `CHST_ASSERT_IMPLIES(a_no_push_full, push, !full, "queue pushed while full")
    `CHST_ASSERT_IMPLIES(a_no_pop_empty, pop, !empty, "queue popped while empty")

endmodule

// ===== hw/rtl/chst_back.sv =====
`include "chained_hash_set_of_tuples_core_assert.svh"

module chst_back
    import chst_pkg::*;
#(
    parameter int BUCKET_BITS = 10,
    parameter int NODE_COUNT  = 1024
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  logic [BUCKET_BITS+KEY_W:0] q_pop_data,
    output logic                       q_pop,
    output logic                       clearing,
    output logic                       reply_valid,
    input  logic                       reply_stall,
    output reply_t                     reply
);

    localparam int IDX_W    = $clog2(NODE_COUNT);
    localparam int CNT_W    = $clog2(NODE_COUNT + 1);
    localparam int BUCKETS  = 1 << BUCKET_BITS;

    // A link is a valid bit above a node index.
    logic [IDX_W:0]         head_mem [BUCKETS];
    logic [KEY_W-1:0]       key_mem  [NODE_COUNT];
    logic [IDX_W:0]         link_mem [NODE_COUNT];

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [BUCKET_BITS-1:0] clear_cnt_reg;
    logic [CNT_W-1:0]       nodes_used_reg;
    logic                   job_cmd_reg;
    logic [KEY_W-1:0]       job_key_reg;
    logic [BUCKET_BITS-1:0] job_bucket_reg;
    logic [IDX_W:0]         head_rd_reg;
    logic [KEY_W-1:0]       key_rd_reg;
    logic [IDX_W:0]         link_rd_reg;
    logic                   reply_valid_reg;
    reply_t                 reply_reg;

    logic                   dispatch;
    logic                   finish;
    logic                   fin_found;
    logic                   room;
    logic                   do_add;
    logic                   head_re;
    logic                   head_we;
    logic [BUCKET_BITS-1:0] head_waddr;
    logic [IDX_W:0]         head_wdata;
    logic                   node_re;
    logic [IDX_W-1:0]       node_raddr;
    logic                   node_we;
    logic [IDX_W-1:0]       new_idx;

    assign clearing    = (state_reg == ST_CLEAR);
    assign reply_valid = reply_valid_reg;
    assign reply       = reply_reg;
    assign room        = nodes_used_reg < CNT_W'(NODE_COUNT);
    assign new_idx     = nodes_used_reg[IDX_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (&clear_cnt_reg)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (dispatch)
                    state_next = ST_HEAD;
            ST_HEAD:
                state_next = finish ? ST_IDLE : ST_NODE;
            ST_NODE:
                if (finish)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    // Sequencer outputs: memory ports, queue pop and the end of a walk.
    always_comb
    begin
        dispatch   = 1'b0;
        finish     = 1'b0;
        fin_found  = 1'b0;
        head_re    = 1'b0;
        head_we    = 1'b0;
        head_waddr = job_bucket_reg;
        head_wdata = {1'b1, new_idx};
        node_re    = 1'b0;
        node_raddr = head_rd_reg[IDX_W-1:0];
        do_add     = 1'b0;
        node_we    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clear_cnt_reg;
                head_wdata = '0;
            end
            ST_IDLE:
            begin
                // Start only when the reply slot is free by the time we finish.
                dispatch = !q_empty && (!reply_valid_reg || !reply_stall);
                head_re  = dispatch;
            end
            ST_HEAD:
            begin
                if (!head_rd_reg[IDX_W])
                    finish = 1'b1;
                else
                    node_re = 1'b1;
            end
            ST_NODE:
            begin
                if (key_rd_reg == job_key_reg)
                begin
                    finish    = 1'b1;
                    fin_found = 1'b1;
                end
                else if (!link_rd_reg[IDX_W])
                begin
                    finish = 1'b1;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = link_rd_reg[IDX_W-1:0];
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase

        // An absent key on insert takes the next free node at the chain head, while free nodes remain.
        if (finish && job_cmd_reg == CMD_INSERT && !fin_found && room)
        begin
            do_add  = 1'b1;
            node_we = 1'b1;
            head_we = 1'b1;
        end
    end

    assign q_pop = dispatch;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clear_cnt_reg   <= '0;
            nodes_used_reg  <= '0;
            reply_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clear_cnt_reg <= clear_cnt_reg + BUCKET_BITS'(1);
            if (do_add)
                nodes_used_reg <= nodes_used_reg + CNT_W'(1);
            if (finish)
                reply_valid_reg <= 1'b1;
            else if (!reply_stall)
                reply_valid_reg <= 1'b0;
        end
    end

    // Job and reply payload.
    always_ff @(posedge clk)
    begin
        if (dispatch)
        begin
            job_key_reg    <= q_pop_data[KEY_W-1:0];
            job_cmd_reg    <= q_pop_data[KEY_W];
            job_bucket_reg <= q_pop_data[BUCKET_BITS+KEY_W:KEY_W+1];
        end
        if (finish)
        begin
            reply_reg.found    <= fin_found;
            reply_reg.added    <= do_add;
            reply_reg.full_res <= (job_cmd_reg == CMD_INSERT) && !fin_found && !room;
        end
    end

    // Bucket head memory.
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        if (head_re)
            head_rd_reg <= head_mem[q_pop_data[BUCKET_BITS+KEY_W:KEY_W+1]];
    end

    // Node key and link memories; a new node links to the old chain head.
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            key_mem[new_idx]  <= job_key_reg;
            link_mem[new_idx] <= head_rd_reg;
        end
        if (node_re)
        begin
            key_rd_reg  <= key_mem[node_raddr];
            link_rd_reg <= link_mem[node_raddr];
        end
    end

    `CHST_ASSERT_HOLDS(a_pool_bound, nodes_used_reg <= CNT_W'(NODE_COUNT), "pool count overflow")
    `CHST_ASSERT_NEXT(a_add_counts, do_add,
        nodes_used_reg == $past(nodes_used_reg) + CNT_W'(1), "add did not allocate a node")
    `CHST_ASSERT_IMPLIES(a_reply_onehot, reply_valid_reg,
        $onehot0({reply_reg.found, reply_reg.added, reply_reg.full_res}), "conflicting reply flags")

endmodule

// ===== hw/rtl/chained_hash_set_of_tuples_core.sv =====
// Path: the hash stage and the queue, then a read of the bucket head and one read per
// chain node compared; the reply is registered at the end.
// The back end takes a new transaction only once the walk of the last one through the head
// and node memories has ended and the reply slot is free or being taken.
// Reset: asynchronous, active low; a clearing pass then writes each of the 2^BUCKET_BITS
// bucket heads in turn to empty every bucket, and no request is taken until it ends.
module chained_hash_set_of_tuples_core
    import chst_pkg::*;
#(
    parameter int BUCKET_BITS = 10,
    parameter int NODE_COUNT  = 1024
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   query_valid,
    output logic   query_stall,
    input  query_t query,
    output logic   reply_valid,
    input  logic   reply_stall,
    output reply_t reply
);

    localparam int ENTRY_W = BUCKET_BITS + KEY_W + 1;

    logic               clearing;
    logic               q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic               q_full;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_pop_data;
    logic               q_empty;

    // Hashing front end.
    chst_front #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_stall (query_stall),
        .query       (query),
        .clearing    (clearing),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // Decoupling queue.
    chst_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Chain walker and storage.
    chst_back #(
        .BUCKET_BITS (BUCKET_BITS),
        .NODE_COUNT  (NODE_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop_data  (q_pop_data),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply       (reply)
    );

endmodule
